FILE: rtl/b2da_pkg.sv
// Package: constants and conversion functions for the binary to decimal ASCII unit.
`default_nettype none
package b2da_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGITS         = 10;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int STAGES         = 4;
    localparam int BITS_PER_STAGE = VALUE_W / STAGES;
    localparam int CNT_W          = $clog2(DIGITS + 1);
    localparam int CHAR_W         = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [BCD_W-1:0]          t_bcd;
    typedef logic [VALUE_W-1:0]        t_value;
    typedef logic [BITS_PER_STAGE-1:0] t_slice;
    typedef logic [CNT_W-1:0]          t_cnt;

    function automatic t_bcd dabble_slice(input t_bcd bcd_in, input t_slice bits);
        t_bcd r;
        r = bcd_in;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r[4*d +: 4] >= 4'd5) begin
                    r[4*d +: 4] = r[4*d +: 4] + 4'd3;
                end
            end
            r = {r[BCD_W-2:0], bits[BITS_PER_STAGE-1-s]};
        end
        return r;
    endfunction

    function automatic t_cnt digit_count(input t_bcd bcd_in);
        t_cnt n;
        n = t_cnt'(1);
        for (int d = 1; d < DIGITS; d++) begin
            if (bcd_in[4*d +: 4] != 4'd0) begin
                n = t_cnt'(d + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/binary_to_decimal_ascii_unit.sv
// Top level: pipelined binary to decimal converter with a per-digit ASCII serialiser.
//
// Each 32-bit number passes through four double-dabble stages (eight bits each), then a
// serialiser sends its decimal digits as ASCII, most significant first, without leading
// zeros, one beat per cycle while i_ready is high, with o_last on the final digit. A
// number has 1 to 10 digits and holds the serialiser until its last digit is taken, so
// the sustained rate is set by the single output beat per cycle. The stages accept a
// new number every cycle while there is room.
`default_nettype none
module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [31:0]       i_value,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last
);

    logic         r_vld [STAGES];
    t_bcd         r_bcd [STAGES];
    t_value       r_bin [STAGES-1];
    logic         adv   [STAGES];

    logic         r_out_vld;
    t_bcd         r_dig;
    t_cnt         r_left;

    logic         ser_free;
    t_cnt         n_cnt;
    t_bcd         n_dig;

    assign ser_free = !r_out_vld || (i_ready && r_left == t_cnt'(0));

    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || ser_free;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_bcd[0] <= dabble_slice(t_bcd'(0), i_value[VALUE_W-1 -: BITS_PER_STAGE]);
            r_bin[0] <= i_value << BITS_PER_STAGE;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
                r_bcd[k] <= dabble_slice(r_bcd[k-1],
                                         r_bin[k-1][VALUE_W-1 -: BITS_PER_STAGE]);
            end
        end
        for (int k = 1; k < STAGES - 1; k++) begin
            if (adv[k]) begin
                r_bin[k] <= r_bin[k-1] << BITS_PER_STAGE;
            end
        end
    end

    always_comb begin
        n_cnt = digit_count(r_bcd[STAGES-1]);
        n_dig = r_bcd[STAGES-1] << (4 * (DIGITS - int'(n_cnt)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_left    <= t_cnt'(0);
        end else if (ser_free) begin
            r_out_vld <= r_vld[STAGES-1];
            r_left    <= n_cnt - t_cnt'(1);
        end else if (i_ready) begin
            r_left    <= r_left - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free) begin
            r_dig <= n_dig;
        end else if (i_ready) begin
            r_dig <= {r_dig[BCD_W-5:0], 4'd0};
        end
    end

    assign o_valid      = r_out_vld;
    assign o_digit_char = ASCII_ZERO + {2'b00, r_dig[BCD_W-1 -: 4]};
    assign o_last       = (r_left == t_cnt'(0));

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_digit_char[3:0] <= 4'd9)
        else $error("digit out of range");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_left < t_cnt'(DIGITS))
        else $error("digit count out of range");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] && !ser_free |=> r_vld[STAGES-1])
        else $error("stalled number dropped");

endmodule
`default_nettype wire
